/* sv/dsa_pkg.sv */
// Shared types, constants and the power-of-ten table for decimal_scale_align.
package dsa_pkg;

	localparam int MAX_SCALE_DEF = 28;
	localparam int SCALE_W       = 5;
	localparam int MANT_W        = 96;
	localparam int WIDE_W        = 192;
	localparam int OUT_W         = 190;
	localparam int LIMB_W        = 32;
	localparam int LIMBS         = 3;
	localparam int POW_ENTRIES   = MAX_SCALE_DEF + 1;

	typedef logic [SCALE_W-1:0]           scale_t;
	typedef logic [MANT_W-1:0]            mant_t;
	typedef logic [WIDE_W-1:0]            wide_t;
	typedef logic [POW_ENTRIES-1:0][MANT_W-1:0] pow10_tab_t;

	// 10^0 .. 10^28, all below 2^94
	function automatic pow10_tab_t build_pow10();
		pow10_tab_t t;
		t[0] = MANT_W'(1);
		for (int i = 1; i < POW_ENTRIES; i++) begin
			t[i] = MANT_W'(t[i-1] * MANT_W'(10));
		end
		return t;
	endfunction

	localparam pow10_tab_t POW10 = build_pow10();

endpackage

/* sv/decimal_scale_align.sv */
// An accepted request passes through stages 1 to 5 to its result on the output register.
// Throughput: one request per cycle while no stall holds; the five-stage multiply pipeline has no loop.
// Stall: when the result register is full and not taken, every stage holds.
// Reset (arst_n low, asynchronous): all stage valid bits clear, pipeline is empty.
// Data registers carry no reset.
// Top level: decimal_scale_align.
module decimal_scale_align #(
	parameter int MAX_SCALE = dsa_pkg::MAX_SCALE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [63:0] mant_a_low,
	input  logic [31:0] mant_a_high,
	input  logic [4:0]  scale_a,
	input  logic [63:0] mant_b_low,
	input  logic [31:0] mant_b_high,
	input  logic [4:0]  scale_b,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [63:0] wide_a_low,
	output logic [63:0] wide_a_mid,
	output logic [61:0] wide_a_top,
	output logic [63:0] wide_b_low,
	output logic [63:0] wide_b_mid,
	output logic [61:0] wide_b_top,
	output logic [4:0]  common_scale
);

	localparam int LW = dsa_pkg::LIMB_W;
	localparam int NL = dsa_pkg::LIMBS;
	localparam int PW = 2 * LW;        // partial product width
	localparam int CW = PW + 2;        // column sum width (up to three products)
	localparam dsa_pkg::scale_t MAX_S = dsa_pkg::SCALE_W'(MAX_SCALE);

	// Whole pipeline moves together; it only freezes when the result register
	// holds an untaken result.
	logic adv;
	assign adv       = !rsp_valid || rsp_ready;
	assign req_ready = adv;

	// ---------------------------------------------------------------------
	// Stage 1: clamp scales, pick which mantissa is scaled up, fetch 10^diff.
	// ---------------------------------------------------------------------
	dsa_pkg::scale_t sa_c, sb_c, diff_c, common_c;
	logic            swap_c;   // high: operand a is the one multiplied
	dsa_pkg::mant_t  ma_c, mb_c;

	always_comb begin
		sa_c     = (scale_a > MAX_S) ? MAX_S : scale_a;
		sb_c     = (scale_b > MAX_S) ? MAX_S : scale_b;
		ma_c     = {mant_a_high, mant_a_low};
		mb_c     = {mant_b_high, mant_b_low};
		swap_c   = (sa_c < sb_c);
		common_c = swap_c ? sb_c : sa_c;
		diff_c   = swap_c ? (sb_c - sa_c) : (sa_c - sb_c);
	end

	logic            valid_s1;
	logic            swap_s1;
	dsa_pkg::scale_t scale_s1;
	dsa_pkg::mant_t  mul_s1, pass_s1, pow_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			swap_s1  <= swap_c;
			scale_s1 <= common_c;
			mul_s1   <= swap_c ? ma_c : mb_c;
			pass_s1  <= swap_c ? mb_c : ma_c;
			pow_s1   <= dsa_pkg::POW10[diff_c];
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: nine 32x32 partial products.
	// ---------------------------------------------------------------------
	logic [NL-1:0][NL-1:0][PW-1:0] pp_s2;
	logic                          valid_s2;
	logic                          swap_s2;
	dsa_pkg::scale_t               scale_s2;
	dsa_pkg::mant_t                pass_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NL; i++) begin
				for (int j = 0; j < NL; j++) begin
					pp_s2[i][j] <= PW'(mul_s1[i*LW +: LW]) * PW'(pow_s1[j*LW +: LW]);
				end
			end
			swap_s2  <= swap_s1;
			scale_s2 <= scale_s1;
			pass_s2  <= pass_s1;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: column sums, column k collects products with i+j == k.
	// ---------------------------------------------------------------------
	logic [2*NL-2:0][CW-1:0] col_s3;
	logic                    valid_s3;
	logic                    swap_s3;
	dsa_pkg::scale_t         scale_s3;
	dsa_pkg::mant_t          pass_s3;
	logic [2*NL-2:0][CW-1:0] col_c;

	always_comb begin
		col_c = '0;
		for (int i = 0; i < NL; i++) begin
			for (int j = 0; j < NL; j++) begin
				col_c[i+j] = col_c[i+j] + CW'(pp_s2[i][j]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s3   <= col_c;
			swap_s3  <= swap_s2;
			scale_s3 <= scale_s2;
			pass_s3  <= pass_s2;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 4: fold columns into an even-offset and an odd-offset vector.
	// ---------------------------------------------------------------------
	dsa_pkg::wide_t  even_s4, odd_s4, even_c, odd_c;
	logic            valid_s4;
	logic            swap_s4;
	dsa_pkg::scale_t scale_s4;
	dsa_pkg::mant_t  pass_s4;

	always_comb begin
		even_c = '0;
		odd_c  = '0;
		for (int k = 0; k < 2*NL-1; k++) begin
			if (k % 2 == 0) begin
				even_c = even_c + (dsa_pkg::WIDE_W'(col_s3[k]) << (k*LW));
			end else begin
				odd_c  = odd_c + (dsa_pkg::WIDE_W'(col_s3[k]) << (k*LW));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			even_s4  <= even_c;
			odd_s4   <= odd_c;
			swap_s4  <= swap_s3;
			scale_s4 <= scale_s3;
			pass_s4  <= pass_s3;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 5: final 192-bit add, route product and passthrough to a/b.
	// ---------------------------------------------------------------------
	dsa_pkg::wide_t  prod_c, pass_wide_c;
	logic [dsa_pkg::OUT_W-1:0] wide_a_s5, wide_b_s5;
	logic            valid_s5;
	dsa_pkg::scale_t scale_s5;

	always_comb begin
		prod_c      = even_s4 + odd_s4;
		pass_wide_c = dsa_pkg::WIDE_W'(pass_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wide_a_s5 <= swap_s4 ? prod_c[dsa_pkg::OUT_W-1:0]
				: pass_wide_c[dsa_pkg::OUT_W-1:0];
			wide_b_s5 <= swap_s4 ? pass_wide_c[dsa_pkg::OUT_W-1:0]
				: prod_c[dsa_pkg::OUT_W-1:0];
			scale_s5  <= scale_s4;
		end
	end

	assign rsp_valid    = valid_s5;
	assign wide_a_low   = wide_a_s5[63:0];
	assign wide_a_mid   = wide_a_s5[127:64];
	assign wide_a_top   = wide_a_s5[189:128];
	assign wide_b_low   = wide_b_s5[63:0];
	assign wide_b_mid   = wide_b_s5[127:64];
	assign wide_b_top   = wide_b_s5[189:128];
	assign common_scale = scale_s5;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	a_scale_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (scale_s1 <= MAX_S))
		else $error("common scale above limit");

	a_pow_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (pow_s1 != '0))
		else $error("power-of-ten lookup returned zero");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> (valid_s2 == $past(valid_s2)) && (valid_s3 == $past(valid_s3))
			&& (valid_s4 == $past(valid_s4)))
		else $error("pipeline moved during stall");

	a_scale_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s4 |=> rsp_valid && (common_scale == $past(scale_s4)))
		else $error("result scale lost on final stage");

endmodule

/* bench/decimal_scale_align_tb.sv */
// Self-checking testbench for decimal_scale_align: random and directed operand pairs.
module decimal_scale_align_tb;

	localparam int SCALE_LIMIT = dsa_pkg::MAX_SCALE_DEF;
	localparam int CYCLE_LIMIT = 200000;  // wide margin over the expected run, for stalls
	localparam int N_RANDOM    = 1500;
	localparam int MAX_REPORTS = 10;

	// One operand pair as it goes over the request channel.
	// wait_drain: hold this request back until every earlier result has come out.
	typedef struct {
		logic [63:0]     mant_a_low;
		logic [31:0]     mant_a_high;
		dsa_pkg::scale_t scale_a;
		logic [63:0]     mant_b_low;
		logic [31:0]     mant_b_high;
		dsa_pkg::scale_t scale_b;
		bit              wait_drain;
	} operand_pair_t;

	// Both mantissas brought to the common scale, split like the output ports.
	typedef struct {
		logic [63:0]     a_low;
		logic [63:0]     a_mid;
		logic [61:0]     a_top;
		logic [63:0]     b_low;
		logic [63:0]     b_mid;
		logic [61:0]     b_top;
		dsa_pkg::scale_t scale;
	} aligned_pair_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            req_valid = 1'b0;
	logic            req_ready;
	logic [63:0]     mant_a_low = '0;
	logic [31:0]     mant_a_high = '0;
	dsa_pkg::scale_t scale_a = '0;
	logic [63:0]     mant_b_low = '0;
	logic [31:0]     mant_b_high = '0;
	dsa_pkg::scale_t scale_b = '0;
	logic            rsp_valid;
	logic            rsp_ready = 1'b0;
	logic [63:0]     wide_a_low;
	logic [63:0]     wide_a_mid;
	logic [61:0]     wide_a_top;
	logic [63:0]     wide_b_low;
	logic [63:0]     wide_b_mid;
	logic [61:0]     wide_b_top;
	dsa_pkg::scale_t common_scale;

	operand_pair_t pending_q[$];     // requests not yet offered
	aligned_pair_t aligned_q[$];     // expected results, oldest first
	operand_pair_t offered_req;      // request now held on the port

	int err_cnt     = 0;
	int sent_cnt    = 0;
	int rcvd_cnt    = 0;
	int equal_cnt   = 0;  // pairs whose scales match after saturation
	int over_cnt    = 0;  // pairs with at least one scale above the limit
	int cycle_cnt   = 0;

	decimal_scale_align dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.mant_a_low   (mant_a_low),
		.mant_a_high  (mant_a_high),
		.scale_a      (scale_a),
		.mant_b_low   (mant_b_low),
		.mant_b_high  (mant_b_high),
		.scale_b      (scale_b),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.wide_a_low   (wide_a_low),
		.wide_a_mid   (wide_a_mid),
		.wide_a_top   (wide_a_top),
		.wide_b_low   (wide_b_low),
		.wide_b_mid   (wide_b_mid),
		.wide_b_top   (wide_b_top),
		.common_scale (common_scale)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Scales above the limit are treated as the limit itself.
	function automatic dsa_pkg::scale_t sat_scale(dsa_pkg::scale_t s);
		return (s > SCALE_LIMIT) ? dsa_pkg::scale_t'(SCALE_LIMIT) : s;
	endfunction

	// Widen both mantissas, scale the one with the smaller exponent up by
	// ten per unit of difference (x*8 + x*2, mod 2^192), keep bits 0..189.
	function automatic aligned_pair_t align_operands(operand_pair_t r);
		dsa_pkg::wide_t  wa;
		dsa_pkg::wide_t  wb;
		dsa_pkg::scale_t sa;
		dsa_pkg::scale_t sb;
		aligned_pair_t   res;
		sa = sat_scale(r.scale_a);
		sb = sat_scale(r.scale_b);
		wa = dsa_pkg::wide_t'({r.mant_a_high, r.mant_a_low});
		wb = dsa_pkg::wide_t'({r.mant_b_high, r.mant_b_low});
		if (sa >= sb) begin
			for (int n = sb; n < sa; n++)
				wb = (wb << 3) + (wb << 1);
			res.scale = sa;
		end else begin
			for (int n = sa; n < sb; n++)
				wa = (wa << 3) + (wa << 1);
			res.scale = sb;
		end
		res.a_low = wa[63:0];
		res.a_mid = wa[127:64];
		res.a_top = wa[189:128];
		res.b_low = wb[63:0];
		res.b_mid = wb[127:64];
		res.b_top = wb[189:128];
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic operand_pair_t make_pair(logic [63:0] alo, logic [31:0] ahi, int sa,
			logic [63:0] blo, logic [31:0] bhi, int sb);
		operand_pair_t p;
		p.mant_a_low  = alo;
		p.mant_a_high = ahi;
		p.scale_a     = dsa_pkg::scale_t'(sa);
		p.mant_b_low  = blo;
		p.mant_b_high = bhi;
		p.scale_b     = dsa_pkg::scale_t'(sb);
		p.wait_drain  = 1'b0;
		return p;
	endfunction

	// Mostly full random; some all-ones, zero, small and high-only values.
	function automatic dsa_pkg::mant_t rand_mant();
		int pick;
		pick = $urandom_range(99);
		if (pick < 60)
			return {$urandom, $urandom, $urandom};
		else if (pick < 72)
			return '1;
		else if (pick < 80)
			return '0;
		else if (pick < 90)
			return dsa_pkg::mant_t'($urandom);
		else
			return {$urandom, 64'd0};
	endfunction

	// Mostly legal scales, with a share of the saturating codes 29..31.
	function automatic dsa_pkg::scale_t rand_scale();
		if ($urandom_range(99) < 85)
			return dsa_pkg::scale_t'($urandom_range(SCALE_LIMIT));
		else
			return dsa_pkg::scale_t'($urandom_range(31, SCALE_LIMIT + 1));
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			err_cnt++;
			if (err_cnt <= MAX_REPORTS)
				$display("MISMATCH result %0d %s: expected %h, got %h",
					rcvd_cnt, name, want, got);
		end
	endtask

	// ------------------------------------------------------------------
	// Request driver: offers requests from pending_q. Valid is held until
	// accepted; a new request is only picked once the port is free. The
	// expected result is queued at the accepting edge.
	// Sender never idles while sent_cnt is in [600, 900), unless a drain-marked request waits.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		bit give;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				aligned_q.push_back(align_operands(offered_req));
				sent_cnt++;
				if (sat_scale(offered_req.scale_a) == sat_scale(offered_req.scale_b))
					equal_cnt++;
				if (offered_req.scale_a > SCALE_LIMIT || offered_req.scale_b > SCALE_LIMIT)
					over_cnt++;
			end
			if (!req_valid || req_ready) begin
				give = 1'b0;
				// a drain-marked request waits for an empty result queue
				if (pending_q.size() > 0 &&
						!(pending_q[0].wait_drain && aligned_q.size() > 0))
					give = (sent_cnt >= 600 && sent_cnt < 900) ||
						($urandom_range(99) >= 36);
				if (give) begin
					offered_req = pending_q.pop_front();
					mant_a_low  <= offered_req.mant_a_low;
					mant_a_high <= offered_req.mant_a_high;
					scale_a     <= offered_req.scale_a;
					mant_b_low  <= offered_req.mant_b_low;
					mant_b_high <= offered_req.mant_b_high;
					scale_b     <= offered_req.scale_b;
					req_valid   <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: checks every accepted result against the oldest
	// expectation, then picks ready for the next edge at random.
	// Receiver never stalls while rcvd_cnt is in [600, 900).
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		aligned_pair_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (aligned_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("UNEXPECTED result with no request pending, scale %0d",
							common_scale);
				end else begin
					want = aligned_q.pop_front();
					check_field("wide_a_low", want.a_low, wide_a_low);
					check_field("wide_a_mid", want.a_mid, wide_a_mid);
					check_field("wide_a_top", 64'(want.a_top), 64'(wide_a_top));
					check_field("wide_b_low", want.b_low, wide_b_low);
					check_field("wide_b_mid", want.b_mid, wide_b_mid);
					check_field("wide_b_top", 64'(want.b_top), 64'(wide_b_top));
					check_field("common_scale", 64'(want.scale), 64'(common_scale));
				end
				rcvd_cnt++;
			end
			rsp_ready <= (rcvd_cnt >= 600 && rcvd_cnt < 900) || ($urandom_range(99) >= 36);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles, %0d results outstanding",
				cycle_cnt, aligned_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		operand_pair_t  p;
		dsa_pkg::mant_t ma;
		dsa_pkg::mant_t mb;
		logic [63:0]    ones64;
		logic [31:0]    ones32;
		ones64 = '1;
		ones32 = '1;

		// Directed: zero, largest mantissas, widest gap both ways, equal scales,
		// saturation of out-of-range scales, single-step gaps, bit patterns.
		pending_q.push_back(make_pair(64'd0, 32'd0, 0, 64'd0, 32'd0, 0));
		pending_q.push_back(make_pair(ones64, ones32, 0, ones64, ones32, 0));
		pending_q.push_back(make_pair(ones64, ones32, 0, ones64, ones32, 28));
		pending_q.push_back(make_pair(ones64, ones32, 28, ones64, ones32, 0));
		pending_q.push_back(make_pair(ones64, ones32, 28, ones64, ones32, 28));
		pending_q.push_back(make_pair(ones64, ones32, 29, ones64, ones32, 0));
		pending_q.push_back(make_pair(ones64, ones32, 0, ones64, ones32, 31));
		pending_q.push_back(make_pair(ones64, ones32, 31, 64'd5, 32'd0, 31));
		pending_q.push_back(make_pair(64'd7, 32'd0, 30, 64'd9, 32'd0, 28));
		pending_q.push_back(make_pair(64'd1, 32'd0, 1, 64'd1, 32'd0, 0));
		pending_q.push_back(make_pair(64'd1, 32'd0, 0, 64'd1, 32'd0, 1));
		pending_q.push_back(make_pair(64'd1, 32'd0, 0, 64'd0, 32'd0, 28));
		pending_q.push_back(make_pair({16{4'h5}}, {8{4'h5}}, 7,
			{16{4'hA}}, {8{4'hA}}, 19));
		pending_q.push_back(make_pair({16{4'hA}}, {8{4'hA}}, 19,
			{16{4'h5}}, {8{4'h5}}, 7));
		pending_q.push_back(make_pair(64'd0, ones32, 3, ones64, 32'd0, 16));
		pending_q.push_back(make_pair(ones64, 32'd0, 16, 64'd0, ones32, 3));
		pending_q.push_back(make_pair(64'd0, 32'd1, 0, 64'd0, 32'h8000_0000, 28));
		pending_q.push_back(make_pair(ones64, ones32, 27, ones64, ones32, 28));
		pending_q.push_back(make_pair({$urandom, $urandom}, $urandom, 2,
			{$urandom, $urandom}, $urandom, 29));
		pending_q.push_back(make_pair({$urandom, $urandom}, $urandom, 31,
			{$urandom, $urandom}, $urandom, 1));

		// Random part; a fifth of the pairs share one scale
		for (int i = 0; i < N_RANDOM; i++) begin
			ma = rand_mant();
			mb = rand_mant();
			p = make_pair(ma[63:0], ma[95:64], rand_scale(), mb[63:0], mb[95:64], 0);
			p.scale_b = ($urandom_range(99) < 20) ? p.scale_a : rand_scale();
			// let the pipeline run dry a few times before a request
			p.wait_drain = (i == 0 || i == 700 || i == 1100);
			pending_q.push_back(p);
		end

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// all requests accepted, then every result back, then a short tail
		// to catch anything the block emits beyond what was asked
		while (pending_q.size() > 0 || req_valid)
			@(posedge clk);
		while (aligned_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Run covered %0d requests: %0d with matching scales, %0d with a saturated scale.",
			sent_cnt, equal_cnt, over_cnt);
		$display("%0d results checked, %0d field mismatches.", rcvd_cnt, err_cnt);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
